// ===== sv/bsc_pkg.sv =====
// ----------------------------------------------------------------------------
// bsc_pkg: shared types and constants
// Widths, fixed constants and helpers for the pressure and temperature
// compensation core.
// ----------------------------------------------------------------------------
`default_nettype none

package bsc_pkg;

	localparam int unsigned RawWidth   = 20;
	localparam int unsigned CalWidth   = 48;
	localparam int unsigned DataWidth  = 64;
	localparam int unsigned CfgIdxWidth = 2;

	localparam logic [63:0] SampleOffset = 64'd1048576;
	localparam logic [63:0] FineOffset   = 64'd128000;
	localparam logic [63:0] DivScale     = 64'd3125;
	localparam logic [63:0] P1Bias       = 64'd1 << 47;
	localparam logic [31:0] RoundTemp    = 32'd128;

	// Register indexes of the configuration port.
	localparam logic [CfgIdxWidth-1:0] RegTempCal  = 2'd0;
	localparam logic [CfgIdxWidth-1:0] RegPressLow = 2'd1;
	localparam logic [CfgIdxWidth-1:0] RegPressMid = 2'd2;
	localparam logic [CfgIdxWidth-1:0] RegPressHigh = 2'd3;

	// Opcode of an input word.
	localparam logic OpTemp  = 1'b0;
	localparam logic OpPress = 1'b1;

	// Request to a shared iterative unit.
	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] b;
	} unit_req_t;

	// Sign-extend a 16-bit calibration word to 64 bits.
	function automatic logic [63:0] sx16(input logic [15:0] w);
		return {{48{w[15]}}, w};
	endfunction

	// Sign-extend a 32-bit value to 64 bits.
	function automatic logic [63:0] sx32(input logic [31:0] w);
		return {{32{w[31]}}, w};
	endfunction

endpackage

`default_nettype wire

// ===== sv/bsc_mul.sv =====
// ----------------------------------------------------------------------------
// bsc_mul: iterative 64-bit multiplier
// Low 64 bits of a 64 x 64 product from one 32 x 32 multiplier, three passes.
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_mul import bsc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire unit_req_t   req,
	output logic             done,
	output logic [63:0]      product
);

	logic [63:0] a_q, b_q, acc_q;
	logic [1:0]  ph_q;
	logic        done_q;
	logic [31:0] x, y;
	logic [63:0] pp;

	always_comb begin
		case (ph_q)
			2'd1: begin
				x = a_q[31:0];
				y = b_q[31:0];
			end
			2'd2: begin
				x = a_q[63:32];
				y = b_q[31:0];
			end
			2'd3: begin
				x = a_q[31:0];
				y = b_q[63:32];
			end
			default: begin
				x = '0;
				y = '0;
			end
		endcase
	end

	assign pp = {32'd0, x} * {32'd0, y};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= 2'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				ph_q <= 2'd1;
			end else if (ph_q == 2'd3) begin
				ph_q   <= 2'd0;
				done_q <= 1'b1;
			end else if (ph_q != 2'd0) begin
				ph_q <= ph_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			b_q <= req.b;
		end
		case (ph_q)
			2'd1: acc_q <= pp;
			2'd2, 2'd3: acc_q <= acc_q + {pp[31:0], 32'd0};
			default: acc_q <= acc_q;
		endcase
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

`default_nettype wire

// ===== sv/bsc_div.sv =====
// ----------------------------------------------------------------------------
// bsc_div: iterative signed 64-bit divider
// Restoring division, one quotient bit a cycle, truncating toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_div import bsc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire unit_req_t   req,
	output logic             done,
	output logic [63:0]      quotient
);

	logic [63:0] n_q, d_q;
	logic [64:0] rem_q;
	logic        neg_q, busy_q, done_q;
	logic [5:0]  cnt_q;
	logic [64:0] trial;
	logic        fits;

	assign trial = {rem_q[63:0], n_q[63]};
	assign fits  = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			n_q   <= req.a[63] ? (64'd0 - req.a) : req.a;
			d_q   <= req.b[63] ? (64'd0 - req.b) : req.b;
			neg_q <= req.a[63] ^ req.b[63];
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? (trial - {1'b0, d_q}) : trial;
			n_q   <= {n_q[62:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (64'd0 - n_q) : n_q;

endmodule

`default_nettype wire

// ===== sv/barometric_sensor_compensation_core.sv =====
// Sequence: a temperature word takes three multiplier passes and a final step; a pressure
// word takes ten multiplier passes, one pass through the bit-serial divider and the set-up,
// check and final add steps; a zero divisor ends at the check, before the divider.
// Throughput: one word at a time; s_axis_tready is high only while the sequencer
// is idle, and a finished result waits in the output register until taken.
// Reset: arst_n clears the sequencer, calibration, fine temperature and result valid.
// ----------------------------------------------------------------------------
// barometric_sensor_compensation_core: integer sensor compensation
// A small sequencer drives one shared 64-bit multiplier and one divider
// through the temperature and pressure compensation formulas.
// ----------------------------------------------------------------------------
`default_nettype none

module barometric_sensor_compensation_core import bsc_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	// configuration write port
	input  wire logic                    cfg_we,
	input  wire logic [CfgIdxWidth-1:0]  cfg_index,
	input  wire logic [CalWidth-1:0]     cfg_data,
	// input words
	input  wire logic                    s_axis_tvalid,
	output logic                         s_axis_tready,
	input  wire logic [23:0]             s_axis_tdata,  // [19:0] raw_sample, rest zero
	input  wire logic                    s_axis_tuser,  // [0] opcode
	// result words
	output logic                         m_axis_tvalid,
	input  wire logic                    m_axis_tready,
	output logic [63:0]                  m_axis_tdata,  // [31:0] temperature, [63:32] pressure
	output logic [1:0]                   m_axis_tuser   // [0] result_kind, [1] zero_divisor
);

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_T_M1, ST_T_M2, ST_T_M3, ST_T_FIN,
		ST_P_SET,
		ST_P_M1, ST_P_M2, ST_P_M3, ST_P_M4, ST_P_M5, ST_P_M6,
		ST_P_CHK, ST_P_M7, ST_P_DIV,
		ST_P_M8, ST_P_M9, ST_P_M10,
		ST_P_F1, ST_P_F2, ST_P_FIN, ST_P_ZERO
	} state_t;

	state_t       state_q;
	logic [47:0]  tcal_q, plo_q, pmid_q, phi_q;
	logic [31:0]  fine_q;
	logic [19:0]  raw_q;
	logic [63:0]  v1_q, v2_q, t_q, m1_q, p_q;
	logic         go_q;

	logic         out_valid_q;
	logic         out_kind_q, out_zero_q;
	logic [31:0]  out_temp_q, out_press_q;

	unit_req_t    mul_req, div_req;
	logic         mul_done, div_done;
	logic [63:0]  mul_prod, div_quot;

	logic         is_mul, is_div, out_free, load_out;
	logic [63:0]  op_a, op_b, h;
	logic [31:0]  ta, tb, ft5, temp_acc;
	logic [63:0]  p_sum;

	// Calibration words.
	logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
	assign t1 = {48'd0, tcal_q[15:0]};
	assign t2 = sx16(tcal_q[31:16]);
	assign t3 = sx16(tcal_q[47:32]);
	assign p1 = {48'd0, plo_q[15:0]};
	assign p2 = sx16(plo_q[31:16]);
	assign p3 = sx16(plo_q[47:32]);
	assign p4 = sx16(pmid_q[15:0]);
	assign p5 = sx16(pmid_q[31:16]);
	assign p6 = sx16(pmid_q[47:32]);
	assign p7 = sx16(phi_q[15:0]);
	assign p8 = sx16(phi_q[31:16]);
	assign p9 = sx16(phi_q[47:32]);

	// Temperature operands wrap at 32 bits.
	assign ta = {15'd0, raw_q[19:3]} - {t1[30:0], 1'b0};
	assign tb = {16'd0, raw_q[19:4]} - t1[31:0];
	assign h  = $signed(p_q) >>> 13;

	always_comb begin
		is_mul = 1'b1;
		op_a   = '0;
		op_b   = '0;
		case (state_q)
			ST_T_M1: begin
				op_a = sx32(ta);
				op_b = t2;
			end
			ST_T_M2: begin
				op_a = sx32(tb);
				op_b = sx32(tb);
			end
			ST_T_M3: begin
				op_a = sx32(v2_q[31:0]);
				op_b = t3;
			end
			ST_P_M1: begin
				op_a = v1_q;
				op_b = v1_q;
			end
			ST_P_M2: begin
				op_a = m1_q;
				op_b = p6;
			end
			ST_P_M3: begin
				op_a = v1_q;
				op_b = p5;
			end
			ST_P_M4: begin
				op_a = m1_q;
				op_b = p3;
			end
			ST_P_M5: begin
				op_a = v1_q;
				op_b = p2;
			end
			ST_P_M6: begin
				op_a = v2_q + P1Bias;
				op_b = p1;
			end
			ST_P_M7: begin
				op_a = ((SampleOffset - {44'd0, raw_q}) << 31) - v2_q;
				op_b = DivScale;
			end
			ST_P_M8: begin
				op_a = p9;
				op_b = h;
			end
			ST_P_M9: begin
				op_a = t_q;
				op_b = h;
			end
			ST_P_M10: begin
				op_a = p8;
				op_b = p_q;
			end
			default: is_mul = 1'b0;
		endcase
	end

	assign is_div = (state_q == ST_P_DIV);

	assign mul_req.start = is_mul && !go_q;
	assign mul_req.a     = op_a;
	assign mul_req.b     = op_b;
	assign div_req.start = is_div && !go_q;
	assign div_req.a     = t_q;
	assign div_req.b     = v1_q;

	bsc_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mul_req),
		.done    (mul_done),
		.product (mul_prod)
	);

	bsc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quot)
	);

	// The result register is free when empty or being drained this cycle.
	assign out_free = !out_valid_q || m_axis_tready;
	// A finished word enters the result register this cycle.
	assign load_out = out_free && (state_q inside {ST_T_FIN, ST_P_FIN, ST_P_ZERO});
	assign ft5      = fine_q + {fine_q[29:0], 2'b00};
	assign temp_acc = ft5 + RoundTemp;
	assign p_sum    = 64'($signed(t_q) >>> 8) + {p7[59:0], 4'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			go_q        <= 1'b0;
			tcal_q      <= '0;
			plo_q       <= '0;
			pmid_q      <= '0;
			phi_q       <= '0;
			fine_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					RegTempCal:   tcal_q <= cfg_data;
					RegPressLow:  plo_q  <= cfg_data;
					RegPressMid:  pmid_q <= cfg_data;
					RegPressHigh: phi_q  <= cfg_data;
					default: ;
				endcase
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			if (mul_req.start || div_req.start) begin
				go_q <= 1'b1;
			end else if (mul_done || div_done) begin
				go_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						state_q <= (s_axis_tuser == OpPress) ? ST_P_SET : ST_T_M1;
					end
				end
				ST_T_M1: begin
					if (mul_done) begin
						v1_q    <= sx32(32'($signed(mul_prod[31:0]) >>> 11));
						state_q <= ST_T_M2;
					end
				end
				ST_T_M2: begin
					if (mul_done) begin
						v2_q    <= sx32(32'($signed(mul_prod[31:0]) >>> 12));
						state_q <= ST_T_M3;
					end
				end
				ST_T_M3: begin
					if (mul_done) begin
						fine_q  <= v1_q[31:0] + 32'($signed(mul_prod[31:0]) >>> 14);
						state_q <= ST_T_FIN;
					end
				end
				ST_T_FIN: begin
					if (out_free) begin
						out_kind_q  <= OpTemp;
						out_zero_q  <= 1'b0;
						out_temp_q  <= 32'($signed(temp_acc) >>> 8);
						out_press_q <= '0;
						state_q     <= ST_IDLE;
					end
				end
				ST_P_SET: begin
					v1_q    <= sx32(fine_q) - FineOffset;
					state_q <= ST_P_M1;
				end
				ST_P_M1: begin
					if (mul_done) begin
						m1_q    <= mul_prod;
						state_q <= ST_P_M2;
					end
				end
				ST_P_M2: begin
					if (mul_done) begin
						v2_q    <= mul_prod + {p4[28:0], 35'd0};
						state_q <= ST_P_M3;
					end
				end
				ST_P_M3: begin
					if (mul_done) begin
						v2_q    <= v2_q + {mul_prod[46:0], 17'd0};
						state_q <= ST_P_M4;
					end
				end
				ST_P_M4: begin
					if (mul_done) begin
						t_q     <= $signed(mul_prod) >>> 8;
						state_q <= ST_P_M5;
					end
				end
				ST_P_M5: begin
					if (mul_done) begin
						// The pressure offset term is parked in m1_q's place.
						m1_q    <= v2_q;
						v2_q    <= t_q + {mul_prod[51:0], 12'd0};
						state_q <= ST_P_M6;
					end
				end
				ST_P_M6: begin
					if (mul_done) begin
						v1_q    <= $signed(mul_prod) >>> 33;
						v2_q    <= m1_q;
						state_q <= ST_P_CHK;
					end
				end
				ST_P_CHK: begin
					state_q <= (v1_q == 64'd0) ? ST_P_ZERO : ST_P_M7;
				end
				ST_P_M7: begin
					if (mul_done) begin
						t_q     <= mul_prod;
						state_q <= ST_P_DIV;
					end
				end
				ST_P_DIV: begin
					if (div_done) begin
						p_q     <= div_quot;
						state_q <= ST_P_M8;
					end
				end
				ST_P_M8: begin
					if (mul_done) begin
						t_q     <= mul_prod;
						state_q <= ST_P_M9;
					end
				end
				ST_P_M9: begin
					if (mul_done) begin
						v1_q    <= $signed(mul_prod) >>> 25;
						state_q <= ST_P_M10;
					end
				end
				ST_P_M10: begin
					if (mul_done) begin
						v2_q    <= $signed(mul_prod) >>> 19;
						state_q <= ST_P_F1;
					end
				end
				ST_P_F1: begin
					t_q     <= p_q + v1_q;
					state_q <= ST_P_F2;
				end
				ST_P_F2: begin
					t_q     <= t_q + v2_q;
					state_q <= ST_P_FIN;
				end
				ST_P_FIN: begin
					if (out_free) begin
						out_kind_q  <= OpPress;
						out_zero_q  <= 1'b0;
						out_temp_q  <= '0;
						out_press_q <= p_sum[31:0];
						state_q     <= ST_IDLE;
					end
				end
				ST_P_ZERO: begin
					if (out_free) begin
						out_kind_q  <= OpPress;
						out_zero_q  <= 1'b1;
						out_temp_q  <= '0;
						out_press_q <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_axis_tvalid) begin
			raw_q <= s_axis_tdata[RawWidth-1:0];
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_press_q, out_temp_q};
	assign m_axis_tuser  = {out_zero_q, out_kind_q};

endmodule

`default_nettype wire

// ===== sv/bsc_checker.sv =====
// ----------------------------------------------------------------------------
// bsc_checker: port-level checks
// Watches the ports of the compensation core over time.
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [63:0] m_axis_tdata,
	input wire logic [1:0]  m_axis_tuser
);

	// A result word holds until taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result word dropped while stalled");

	// The core works on one word at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted while busy");

	// Temperature results carry no pressure and no zero-divisor flag.
	a_temp_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |->
			m_axis_tdata[63:32] == 32'd0 && !m_axis_tuser[1])
		else $error("temperature word carries pressure fields");

	// A zero divisor forces zero pressure and zero temperature.
	a_zero_div: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == 64'd0 && m_axis_tuser[0])
		else $error("zero-divisor word with nonzero data");

endmodule

bind barometric_sensor_compensation_core bsc_checker u_bsc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
